### rtl/core/wds_pkg.sv
// Shared types and constants for the descrambler with seed recovery.
package wds_pkg;

  localparam int unsigned MaxPayloadBytesDefault = 4095;
  localparam int unsigned PayloadBytesW          = 12;
  localparam int unsigned ByteW                  = 8;
  localparam int unsigned SeedW                  = 7;
  localparam int unsigned BitPosW                = 16;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

### rtl/core/wds_core.sv
// Scrambler state, bit position and byte assembly; one bit per enable.
module wds_core #(
  parameter int unsigned MAX_PAYLOAD_BYTES = wds_pkg::MaxPayloadBytesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic                                  bit_i,
  input  logic [wds_pkg::PayloadBytesW-1:0]     payload_bytes_i,
  output logic                                  emit_o,
  output wds_pkg::result_t                      result_o
);

  localparam int unsigned ByteIdxW = wds_pkg::BitPosW - 3;
  localparam logic [16:0] MaxLen   = 17'(MAX_PAYLOAD_BYTES);

  logic [wds_pkg::SeedW-1:0]         state_q, state_d;
  logic [wds_pkg::BitPosW-1:0]       pos_q, pos_d;
  logic [wds_pkg::ByteW-1:0]         acc_q, acc_d, acc_bit;
  logic [wds_pkg::PayloadBytesW-1:0] plen;
  logic [ByteIdxW-1:0]               end_idx;
  logic [2:0]                        seed_sh;
  logic                              in_seed, fb, last;

  always_comb begin
    if ({5'b0, payload_bytes_i} > MaxLen) begin
      plen = MaxLen[wds_pkg::PayloadBytesW-1:0];
    end else begin
      plen = payload_bytes_i;
    end
    end_idx = ByteIdxW'(plen) + ByteIdxW'(1);
  end

  always_comb begin
    in_seed = (pos_q[wds_pkg::BitPosW-1:3] == '0) && (pos_q[2:0] != 3'd7);
    seed_sh = 3'd6 - pos_q[2:0];
    fb      = state_q[6] ^ state_q[3];
    emit_o  = (pos_q[2:0] == 3'd7);
    last    = emit_o && (pos_q[wds_pkg::BitPosW-1:3] >= end_idx);
    state_d = state_q;
    acc_bit = '0;
    if (in_seed) begin
      acc_bit = wds_pkg::ByteW'(bit_i) << seed_sh;
      state_d = state_q | acc_bit[wds_pkg::SeedW-1:0];
    end else begin
      acc_bit = wds_pkg::ByteW'(fb ^ bit_i) << pos_q[2:0];
      state_d = {state_q[5:0], fb};
    end
    result_o.data = acc_q | acc_bit;
    result_o.last = last;
    acc_d = result_o.data;
    pos_d = pos_q + wds_pkg::BitPosW'(1);
    if (emit_o) begin
      acc_d = '0;
      if (last) begin
        pos_d   = '0;
        state_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
      acc_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### rtl/core/wlan_descrambler_seed_recovery.sv
// Top level: input register, descrambler core and result register.
// Usage:
//   Input channel: one scrambled bit per item (in_valid_i / in_stall_o).
//   Output channel: one byte per eight bits, last_byte_o on the frame's
//   final byte (out_valid_o / out_stall_i).
//   A frame is (payload_bytes + 2) * 8 bits; the first seven bits are the
//   seed and come back in bits 6..0 of byte 0. payload_bytes above
//   MAX_PAYLOAD_BYTES is clamped. Write cfg_wdata_i with cfg_we_i while idle.
// Timing:
//   An item is registered at its accept edge and processed at the next
//   edge the result register can load; out_valid_o rises when the eighth
//   bit is processed. Throughput is one bit per cycle while no result waits
//   under out_stall_i, set by the LFSR update in the core.
// Stall:
//   While a result waits, one more bit is taken into the input register,
//   then in_stall_o rises until the result is taken.
// Reset:
//   Length, scrambler state, bit position, byte accumulator and the valid
//   flags of both registers clear; the next bit starts a new frame.
module wlan_descrambler_seed_recovery #(
  parameter int unsigned MAX_PAYLOAD_BYTES = wds_pkg::MaxPayloadBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wds_pkg::PayloadBytesW-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              scrambled_bit_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wds_pkg::ByteW-1:0]         data_byte_o,
  output logic                              last_byte_o
);

  logic [wds_pkg::PayloadBytesW-1:0] payload_q;
  logic                              s1_valid_q, s1_bit_q;
  logic                              out_valid_q;
  wds_pkg::result_t                  out_q, core_res;
  logic                              advance, step, emit;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  wds_core #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .bit_i          (s1_bit_q),
    .payload_bytes_i(payload_q),
    .emit_o         (emit),
    .result_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        payload_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= step && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_bit_q <= scrambled_bit_i;
    end
    if (step && emit) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = out_q.data;
  assign last_byte_o = out_q.last;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without a waiting result");

  a_drain_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !s1_valid_q |=> !out_valid_q)
    else $error("result appeared with no bit processed");

  a_item_reaches_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |-> step)
    else $error("registered bit not processed with free result register");

endmodule

### tb/wlan_descrambler_seed_recovery_checker.sv
// Checker for the descrambler: tracks the channels, predicts each byte and compares.
`timescale 1ns / 100ps

module wlan_descrambler_seed_recovery_checker #(
  parameter int unsigned MAX_PAYLOAD_BYTES = wds_pkg::MaxPayloadBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wds_pkg::PayloadBytesW-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              scrambled_bit_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [wds_pkg::ByteW-1:0]         data_byte_i,
  input  logic                              last_byte_i,
  output int                                errors_o,
  output int                                pending_o
);

  logic [wds_pkg::PayloadBytesW-1:0] payload_len;
  logic [wds_pkg::SeedW-1:0]         lfsr;
  logic [wds_pkg::BitPosW-1:0]       bit_pos;
  logic [wds_pkg::ByteW-1:0]         byte_acc;
  wds_pkg::result_t                  byte_queue[$];
  int                                errors = 0;

  task automatic descramble_bit(input logic b);
    int               idx;
    logic             fb;
    int unsigned      eff_len;
    int unsigned      frame_len;
    wds_pkg::result_t res;
    if (bit_pos < wds_pkg::SeedW) begin
      idx = int'(wds_pkg::SeedW) - 1 - int'(bit_pos);
      lfsr[idx] = lfsr[idx] | b;
      byte_acc[idx] = byte_acc[idx] | b;
    end else begin
      fb = lfsr[6] ^ lfsr[3];
      byte_acc[bit_pos[2:0]] = byte_acc[bit_pos[2:0]] | (fb ^ b);
      lfsr = {lfsr[wds_pkg::SeedW-2:0], fb};
    end
    if (bit_pos[2:0] == 3'd7) begin
      eff_len = (payload_len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(payload_len);
      frame_len = (eff_len + 2) * wds_pkg::ByteW;
      res.data = byte_acc;
      res.last = ((int'(bit_pos) + 1) >= frame_len);
      byte_queue.push_back(res);
      byte_acc = '0;
      if (res.last) begin
        bit_pos = '0;
        lfsr = '0;
      end else begin
        bit_pos = bit_pos + 1'b1;
      end
    end else begin
      bit_pos = bit_pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    wds_pkg::result_t exp_byte;
    if (!rst_ni) begin
      payload_len = '0;
      lfsr = '0;
      bit_pos = '0;
      byte_acc = '0;
      byte_queue.delete();
      pending_o <= 0;
      errors_o <= errors;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (byte_queue.size() == 0) begin
          errors++;
          $error("unexpected item: data_byte %02h last_byte %0b", data_byte_i, last_byte_i);
        end else begin
          exp_byte = byte_queue.pop_front();
          if (data_byte_i !== exp_byte.data) begin
            errors++;
            $error("data_byte expected %02h actual %02h", exp_byte.data, data_byte_i);
          end
          if (last_byte_i !== exp_byte.last) begin
            errors++;
            $error("last_byte expected %0b actual %0b", exp_byte.last, last_byte_i);
          end
        end
      end
      if (cfg_we_i) payload_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) descramble_bit(scrambled_bit_i);
      pending_o <= byte_queue.size();
      errors_o <= errors;
    end
  end

endmodule

### tb/wlan_descrambler_seed_recovery_tb.sv
// Testbench top: clock, reset, bit stimulus, output stall, watchdog and verdict.
`timescale 1ns / 100ps

module wlan_descrambler_seed_recovery_tb;

  localparam int unsigned MaxPayload    = wds_pkg::MaxPayloadBytesDefault;
  localparam int          RandomBits    = 500;
  localparam int          PauseCycles   = 8;
  localparam int          WatchdogLimit = 4000;

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              cfg_we_i        = 1'b0;
  logic [wds_pkg::PayloadBytesW-1:0] cfg_wdata_i     = '0;
  logic                              in_valid_i      = 1'b0;
  logic                              in_stall_o;
  logic                              scrambled_bit_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i     = 1'b0;
  logic [wds_pkg::ByteW-1:0]         data_byte_o;
  logic                              last_byte_o;

  int errors;
  int pending;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int bits_sent  = 0;
  int len_writes = 0;
  int frames     = 0;

  always #6 clk_i = ~clk_i;

  wlan_descrambler_seed_recovery #(
    .MAX_PAYLOAD_BYTES(MaxPayload)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .scrambled_bit_i(scrambled_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .last_byte_o    (last_byte_o)
  );

  wlan_descrambler_seed_recovery_checker #(
    .MAX_PAYLOAD_BYTES(MaxPayload)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .scrambled_bit_i(scrambled_bit_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_i    (data_byte_o),
    .last_byte_i    (last_byte_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    if (out_valid_o && !out_stall_i && last_byte_o) frames++;
  end

  task automatic send_bit(input logic b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    scrambled_bit_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bits_sent++;
  endtask

  // wait until every expected byte is out, then let the pipeline settle
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PauseCycles) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [wds_pkg::PayloadBytesW-1:0] len);
    drain_outputs();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_writes++;
  endtask

  initial begin : stimulus
    int                                phase;
    int                                n;
    logic [wds_pkg::PayloadBytesW-1:0] len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-ones seed, shortest frame at reset length
    repeat (16) send_bit(1'b1);
    // longest length, then cut short mid-frame
    set_length('1);
    repeat (8) send_bit(1'b0);
    set_length('0);
    for (int i = 0; i < 8; i++) send_bit(i[0]);

    phase = 0;
    while (bits_sent < RandomBits + 32) begin
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      if ($urandom_range(0, 9) == 0) len = wds_pkg::PayloadBytesW'($urandom_range(0, 4095));
      else len = wds_pkg::PayloadBytesW'($urandom_range(0, 4));
      set_length(len);
      n = int'($urandom_range(1, 64));
      repeat (n) send_bit(1'($urandom_range(0, 1)));
      phase++;
    end
    drain_outputs();

    $display("Sent %0d bits in %0d phases with %0d length writes; %0d frames closed.",
             bits_sent, phase, len_writes, frames);
    $display("Lengths ranged 0..4095 with mid-frame changes, under all idle/stall mixes.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no item moved for %0d cycles", WatchdogLimit);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/wds_pkg.sv
rtl/core/wds_core.sv
rtl/core/wlan_descrambler_seed_recovery.sv
tb/wlan_descrambler_seed_recovery_checker.sv
tb/wlan_descrambler_seed_recovery_tb.sv
